// ===== design/fps_pkg.sv =====
// Shared types and constants for the frame playback sequencer.
`default_nettype none

package fps_pkg;

    localparam int ACT_W  = 4;
    localparam int VAL_W  = 16;
    localparam int FRM_W  = 16;
    localparam int CNT_W  = 32;
    localparam int MODE_W = 2;
    localparam int ERR_W  = 2;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [ACT_W-1:0] ACT_TICK   = 4'd0;
    localparam logic [ACT_W-1:0] ACT_PLAY   = 4'd1;
    localparam logic [ACT_W-1:0] ACT_PAUSE  = 4'd2;
    localparam logic [ACT_W-1:0] ACT_STOP   = 4'd3;
    localparam logic [ACT_W-1:0] ACT_TOGGLE = 4'd4;
    localparam logic [ACT_W-1:0] ACT_SEEK   = 4'd5;
    localparam logic [ACT_W-1:0] ACT_NEXT   = 4'd6;
    localparam logic [ACT_W-1:0] ACT_PREV   = 4'd7;
    localparam logic [ACT_W-1:0] ACT_LOAD   = 4'd8;

    localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PLAYING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_NO_FRAMES = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SEEK_OOR  = 2'd2;

    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_LOOP   = 1'b1;

    localparam logic [FRM_W-1:0] PERIOD_RESET = 16'd33;
    localparam logic             LOOP_RESET   = 1'b1;

    typedef struct packed {
        logic [FRM_W-1:0] period;
        logic             loop_en;
    } t_cfg;

    typedef struct packed {
        logic [FRM_W-1:0]  current_frame;
        logic [FRM_W-1:0]  total_frames;
        logic [MODE_W-1:0] mode;
        logic              changed;
        logic [ERR_W-1:0]  error;
        logic [CNT_W-1:0]  frames_played;
    } t_res;

endpackage

`default_nettype wire

// ===== design/fps_cmd_if.sv =====
// Command channel: valid/ready handshake carrying one action item.
`default_nettype none

interface fps_cmd_if import fps_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [VAL_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

// ===== design/fps_res_if.sv =====
// Result channel: valid/ready handshake carrying one status item.
`default_nettype none

interface fps_res_if import fps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FRM_W-1:0]  current_frame;
    logic [FRM_W-1:0]  total_frames;
    logic [MODE_W-1:0] mode;
    logic              changed;
    logic [ERR_W-1:0]  error;
    logic [CNT_W-1:0]  frames_played;

    modport source (output valid, output current_frame, output total_frames, output mode,
                    output changed, output error, output frames_played, input ready);
    modport sink (input valid, input current_frame, input total_frames, input mode,
                  input changed, input error, input frames_played, output ready);
endinterface

`default_nettype wire

// ===== design/frame_playback_sequencer.sv =====
// Top level of the frame playback sequencer.
// Each command item (tick, play, pause, stop, toggle, seek, next, previous,
// load count) yields exactly one result item with the frame, frame count,
// mode, change flag, error code and played-frame count after that command.
// One item per clock is sustained while results are not stalled; an item
// goes from the command register through the next-state logic into the
// result register. While a result is stalled the command register still
// takes one more command before ready drops. Configuration (frame period
// at address 0, loop enable at address 4) is written over APB; the user
// is to write it only while idle, which the block itself does not enforce.
`default_nettype none

module frame_playback_sequencer import fps_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    fps_cmd_if.sink                i_cmd,
    fps_res_if.source              o_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output      logic [DATA_W-1:0] prdata,
    output      logic              pready
);

    t_cfg             cfg;
    t_res             res;
    logic             r_in_vld;
    logic [ACT_W-1:0] r_act;
    logic [VAL_W-1:0] r_val;
    logic             r_out_vld;
    t_res             r_out;
    logic             advance;

    fps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_action (r_act),
        .i_value  (r_val),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    assign advance     = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_cmd.ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_vld <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_act <= i_cmd.action;
            r_val <= i_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.current_frame = r_out.current_frame;
    assign o_res.total_frames  = r_out.total_frames;
    assign o_res.mode          = r_out.mode;
    assign o_res.changed       = r_out.changed;
    assign o_res.error         = r_out.error;
    assign o_res.frames_played = r_out.frames_played;

endmodule

`default_nettype wire

// ===== design/fps_cfg.sv =====
// APB configuration registers: frame period and loop enable.
`default_nettype none

module fps_cfg import fps_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output      logic [DATA_W-1:0] prdata,
    output      logic              pready,
    output      t_cfg              o_cfg
);

    logic             r_loop;
    logic [FRM_W-1:0] r_period;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_loop   <= LOOP_RESET;
        end else if (wr_en) begin
            if (reg_sel == REG_PERIOD) begin
                r_period <= pwdata[FRM_W-1:0];
            end else begin
                r_loop <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (reg_sel == REG_LOOP) begin
            prdata = {{(DATA_W-1){1'b0}}, r_loop};
        end else begin
            prdata = {{(DATA_W-FRM_W){1'b0}}, r_period};
        end
    end

    assign o_cfg.period  = r_period;
    assign o_cfg.loop_en = r_loop;

endmodule

`default_nettype wire

// ===== design/fps_core.sv =====
// Playback state registers and the per-item next-state logic.
`default_nettype none

module fps_core import fps_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [ACT_W-1:0] i_action,
    input  wire logic [VAL_W-1:0] i_value,
    input  wire t_cfg             i_cfg,
    output      t_res             o_res
);

    logic [MODE_W-1:0] r_mode, n_mode;
    logic [FRM_W-1:0]  r_idx, n_idx;
    logic [FRM_W-1:0]  r_tot, n_tot;
    logic [FRM_W-1:0]  r_ms, n_ms;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              chg;
    logic [ERR_W-1:0]  err;
    logic [FRM_W:0]    idx_inc;
    logic              at_end;
    logic [FRM_W-1:0]  last;
    logic [FRM_W-1:0]  ms_inc;
    logic [FRM_W-1:0]  tgt;
    logic              playing;
    logic              has_frames;

    assign idx_inc    = {1'b0, r_idx} + {{FRM_W{1'b0}}, 1'b1};
    assign at_end     = idx_inc >= {1'b0, r_tot};
    assign last       = r_tot - {{(FRM_W-1){1'b0}}, 1'b1};
    assign ms_inc     = (r_ms != {FRM_W{1'b1}}) ? r_ms + {{(FRM_W-1){1'b0}}, 1'b1} : r_ms;
    assign playing    = (r_mode == MODE_PLAYING);
    assign has_frames = (r_tot != '0);

    always_comb begin
        n_mode = r_mode;
        n_idx  = r_idx;
        n_tot  = r_tot;
        n_ms   = r_ms;
        n_cnt  = r_cnt;
        chg    = 1'b0;
        err    = ERR_NONE;
        tgt    = r_idx;
        case (i_action)
            ACT_TICK: begin
                if (playing && has_frames) begin
                    n_ms = ms_inc;
                    if (ms_inc >= i_cfg.period) begin
                        chg = 1'b1;
                        if (!at_end) begin
                            n_idx = idx_inc[FRM_W-1:0];
                        end else if (i_cfg.loop_en) begin
                            n_idx = '0;
                        end else begin
                            n_idx  = last;
                            n_mode = MODE_PAUSED;
                        end
                        n_ms = '0;
                        if (r_cnt != {CNT_W{1'b1}}) begin
                            n_cnt = r_cnt + {{(CNT_W-1){1'b0}}, 1'b1};
                        end
                    end
                end
            end
            ACT_PAUSE: begin
                if (playing) begin
                    n_mode = MODE_PAUSED;
                    chg    = 1'b1;
                end
            end
            ACT_PLAY, ACT_TOGGLE: begin
                if (i_action == ACT_TOGGLE && playing) begin
                    n_mode = MODE_PAUSED;
                    chg    = 1'b1;
                end else if (!has_frames) begin
                    err = ERR_NO_FRAMES;
                end else if (!playing) begin
                    n_mode = MODE_PLAYING;
                    n_ms   = '0;
                    chg    = 1'b1;
                end
            end
            ACT_STOP: begin
                n_mode = MODE_STOPPED;
                n_idx  = '0;
                n_cnt  = '0;
                chg    = 1'b1;
            end
            ACT_SEEK: begin
                if (!has_frames) begin
                    err = ERR_NO_FRAMES;
                end else if (i_value >= r_tot) begin
                    err = ERR_SEEK_OOR;
                end else if (i_value != r_idx) begin
                    n_idx = i_value;
                    n_ms  = '0;
                    chg   = 1'b1;
                end
            end
            ACT_NEXT: begin
                if (has_frames) begin
                    if (!at_end) begin
                        tgt = idx_inc[FRM_W-1:0];
                    end else if (i_cfg.loop_en) begin
                        tgt = '0;
                    end else begin
                        tgt = last;
                        if (playing) begin
                            n_mode = MODE_PAUSED;
                            chg    = 1'b1;
                        end
                    end
                    if (tgt != r_idx) begin
                        n_idx = tgt;
                        n_ms  = '0;
                        chg   = 1'b1;
                    end
                end
            end
            ACT_PREV: begin
                if (has_frames) begin
                    if (r_idx != '0) begin
                        tgt = r_idx - {{(FRM_W-1){1'b0}}, 1'b1};
                    end else if (i_cfg.loop_en) begin
                        tgt = last;
                    end else begin
                        tgt = '0;
                    end
                    if (tgt != r_idx) begin
                        n_idx = tgt;
                        n_ms  = '0;
                        chg   = 1'b1;
                    end
                end
            end
            ACT_LOAD: begin
                n_tot = i_value;
                if (i_value == '0) begin
                    n_idx  = '0;
                    n_mode = MODE_STOPPED;
                end else if (r_idx >= i_value) begin
                    n_idx = i_value - {{(FRM_W-1){1'b0}}, 1'b1};
                end
                chg = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_STOPPED;
            r_idx  <= '0;
            r_tot  <= '0;
            r_ms   <= '0;
            r_cnt  <= '0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_idx  <= n_idx;
            r_tot  <= n_tot;
            r_ms   <= n_ms;
            r_cnt  <= n_cnt;
        end
    end

    assign o_res.current_frame = n_idx;
    assign o_res.total_frames  = n_tot;
    assign o_res.mode          = n_mode;
    assign o_res.changed       = chg;
    assign o_res.error         = err;
    assign o_res.frames_played = n_cnt;

endmodule

`default_nettype wire

// ===== design/fps_checker.sv =====
// Port-level checks on the sequencer's result stream, bound to the top level.
`default_nettype none

module fps_checker import fps_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              i_ready,
    input wire logic [FRM_W-1:0]  i_frame,
    input wire logic [FRM_W-1:0]  i_total,
    input wire logic [MODE_W-1:0] i_mode,
    input wire logic              i_changed,
    input wire logic [ERR_W-1:0]  i_error
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result item dropped while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    a_err_nochg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_error != ERR_NONE) |-> !i_changed)
        else $error("error item reports a change");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_total == '0) |-> (i_frame == '0) && (i_mode != MODE_PLAYING))
        else $error("empty sequence with nonzero frame or playing");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_total != '0) |-> (i_frame < i_total))
        else $error("frame index beyond frame count");

endmodule

bind frame_playback_sequencer fps_checker u_fps_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_res.valid),
    .i_ready   (o_res.ready),
    .i_frame   (o_res.current_frame),
    .i_total   (o_res.total_frames),
    .i_mode    (o_res.mode),
    .i_changed (o_res.changed),
    .i_error   (o_res.error)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the frame playback sequencer: directed table, then random commands.
`timescale 1ns / 1ps

module tb;
    import fps_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int PLAN_N          = 30;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 4'd15;

    localparam logic [FRM_W-1:0] PHASE_PERIOD [PHASES] =
        '{16'd1, 16'd2, 16'd65535, 16'd3, 16'd1, 16'd0, 16'd5, 16'd33};
    localparam logic PHASE_LOOP [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    typedef enum logic [1:0] {ROW_CMD, ROW_PERIOD, ROW_LOOP} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [ACT_W-1:0] act;
        logic [VAL_W-1:0] val;
        logic             pinned;
        t_res             want;
    } t_row;

    typedef struct packed {
        logic on;
        t_res want;
    } t_pin;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata, prdata;

    fps_cmd_if cmd_if ();
    fps_res_if res_if ();

    frame_playback_sequencer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // sequencer shadow state and register copy
    logic [MODE_W-1:0] seq_mode   = MODE_STOPPED;
    logic [FRM_W-1:0]  seq_frame  = '0;
    logic [FRM_W-1:0]  seq_total  = '0;
    logic [FRM_W-1:0]  seq_ms     = '0;
    logic [CNT_W-1:0]  seq_played = '0;
    logic [FRM_W-1:0]  cfg_period = PERIOD_RESET;
    logic              cfg_loop   = LOOP_RESET;
    logic              step_chg;

    t_res status_q [$];
    t_pin pinned_q [$];
    t_row plan [PLAN_N];

    t_pin pin_now;
    t_res predicted, seen;
    logic quiet = 1'b0;
    int   stall_left = 0;
    int   bad_count = 0;
    int   results_checked = 0;
    int   cmds_sent = 0;
    int   reg_writes = 0;
    int   cycles = 0;

    function automatic t_res snap(input logic [FRM_W-1:0] frame, input logic [FRM_W-1:0] total,
                                  input logic [MODE_W-1:0] mode, input logic chg,
                                  input logic [ERR_W-1:0] err, input logic [CNT_W-1:0] played);
        return '{frame, total, mode, chg, err, played};
    endfunction

    function automatic string describe(input t_res r);
        return $sformatf("frame=%0d total=%0d mode=%0d changed=%0d error=%0d played=%0d",
                         r.current_frame, r.total_frames, r.mode, r.changed, r.error,
                         r.frames_played);
    endfunction

    function automatic logic pause_now();
        if (seq_mode == MODE_PLAYING) begin
            seq_mode = MODE_PAUSED;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [ERR_W-1:0] start_play();
        if (seq_total == 0)
            return ERR_NO_FRAMES;
        if (seq_mode != MODE_PLAYING) begin
            seq_mode = MODE_PLAYING;
            seq_ms   = '0;
            step_chg = 1'b1;
        end
        return ERR_NONE;
    endfunction

    function automatic void move_to(input logic [FRM_W-1:0] target);
        if (target != seq_frame) begin
            seq_frame = target;
            seq_ms    = '0;
            step_chg  = 1'b1;
        end
    endfunction

    function automatic t_res apply_command(input logic [ACT_W-1:0] act,
                                           input logic [VAL_W-1:0] val);
        logic [ERR_W-1:0] err;
        logic [FRM_W-1:0] target;
        err      = ERR_NONE;
        step_chg = 1'b0;
        case (act)
            ACT_TICK: begin
                if (seq_mode == MODE_PLAYING && seq_total != 0) begin
                    if (seq_ms != '1)
                        seq_ms = seq_ms + 1'b1;
                    if (seq_ms >= cfg_period) begin
                        if (17'(seq_frame) + 17'd1 >= 17'(seq_total)) begin
                            if (cfg_loop) begin
                                seq_frame = '0;
                                step_chg  = 1'b1;
                            end else begin
                                seq_frame = seq_total - 1'b1;
                                step_chg  = pause_now();
                            end
                        end else begin
                            seq_frame = seq_frame + 1'b1;
                            step_chg  = 1'b1;
                        end
                        seq_ms = '0;
                        if (seq_played != '1)
                            seq_played = seq_played + 1'b1;
                    end
                end
            end
            ACT_PLAY:  err = start_play();
            ACT_PAUSE: step_chg = pause_now();
            ACT_STOP: begin
                seq_mode   = MODE_STOPPED;
                seq_frame  = '0;
                seq_played = '0;
                step_chg   = 1'b1;
            end
            ACT_TOGGLE: begin
                if (seq_mode == MODE_PLAYING)
                    step_chg = pause_now();
                else
                    err = start_play();
            end
            ACT_SEEK: begin
                if (seq_total == 0)
                    err = ERR_NO_FRAMES;
                else if (val >= seq_total)
                    err = ERR_SEEK_OOR;
                else
                    move_to(val);
            end
            ACT_NEXT: begin
                if (seq_total != 0) begin
                    if (17'(seq_frame) + 17'd1 >= 17'(seq_total)) begin
                        if (cfg_loop) begin
                            target = '0;
                        end else begin
                            target = seq_total - 1'b1;
                            if (pause_now())
                                step_chg = 1'b1;
                        end
                    end else begin
                        target = seq_frame + 1'b1;
                    end
                    move_to(target);
                end
            end
            ACT_PREV: begin
                if (seq_total != 0) begin
                    if (seq_frame == 0)
                        target = cfg_loop ? seq_total - 1'b1 : '0;
                    else
                        target = seq_frame - 1'b1;
                    move_to(target);
                end
            end
            ACT_LOAD: begin
                // 16-bit count can never exceed the frame limit
                seq_total = val;
                if (seq_total == 0) begin
                    seq_frame = '0;
                    seq_mode  = MODE_STOPPED;
                end else if (seq_frame >= seq_total) begin
                    seq_frame = seq_total - 1'b1;
                end
                step_chg = 1'b1;
            end
            default: ;
        endcase
        return '{seq_frame, seq_total, seq_mode, step_chg, err, seq_played};
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycles, status_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && cmd_if.valid && cmd_if.ready) begin
            pin_now   = pinned_q.pop_front();
            predicted = apply_command(cmd_if.action, cmd_if.value);
            status_q.push_back(pin_now.on ? pin_now.want : predicted);
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            seen = '{res_if.current_frame, res_if.total_frames, res_if.mode, res_if.changed,
                     res_if.error, res_if.frames_played};
            if (status_q.size() == 0) begin
                bad_count++;
                if (bad_count <= 10)
                    $display("unexpected result: %s", describe(seen));
            end else begin
                predicted = status_q.pop_front();
                results_checked++;
                if (seen !== predicted) begin
                    bad_count++;
                    if (bad_count <= 10) begin
                        $display("mismatch on result %0d", results_checked);
                        $display("  expected %s", describe(predicted));
                        $display("  actual   %s", describe(seen));
                    end
                end
            end
        end
    end

    // result backpressure
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && stall_left != 0) begin
                stall_left--;
                res_if.ready = 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 18);
                res_if.ready = 1'b0;
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val,
                            input logic pinned, input t_res want);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            cmd_if.valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        pinned_q.push_back('{pinned, want});
        cmd_if.valid  = 1'b1;
        cmd_if.action = act;
        cmd_if.value  = val;
        cmds_sent++;
        do @(posedge i_clk); while (!cmd_if.ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        cmd_if.valid = 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = ADDR_W'({idx, 2'b00});
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_PERIOD)
            cfg_period = data[FRM_W-1:0];
        else
            cfg_loop = data[0];
        reg_writes++;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial begin
        logic [ACT_W-1:0] act;
        logic [VAL_W-1:0] val;
        int pick;

        cmd_if.valid  = 1'b0;
        cmd_if.action = ACT_TICK;
        cmd_if.value  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;

        plan = '{
            '{ROW_CMD, ACT_PLAY,   'h0000, 1'b1, snap(0, 0, MODE_STOPPED, 0, ERR_NO_FRAMES, 0)},
            '{ROW_CMD, ACT_TOGGLE, 'h0000, 1'b1, snap(0, 0, MODE_STOPPED, 0, ERR_NO_FRAMES, 0)},
            '{ROW_CMD, ACT_SEEK,   'h0000, 1'b1, snap(0, 0, MODE_STOPPED, 0, ERR_NO_FRAMES, 0)},
            '{ROW_CMD, ACT_NEXT,   'h0000, 1'b1, snap(0, 0, MODE_STOPPED, 0, ERR_NONE, 0)},
            '{ROW_CMD, ACT_PREV,   'h0000, 1'b1, snap(0, 0, MODE_STOPPED, 0, ERR_NONE, 0)},
            '{ROW_CMD, ACT_UNUSED, 'hFFFF, 1'b1, snap(0, 0, MODE_STOPPED, 0, ERR_NONE, 0)},
            '{ROW_CMD, ACT_LOAD,   'hFFFF, 1'b1, snap(0, 'hFFFF, MODE_STOPPED, 1, ERR_NONE, 0)},
            '{ROW_CMD, ACT_SEEK,   'hFFFF, 1'b1, snap(0, 'hFFFF, MODE_STOPPED, 0, ERR_SEEK_OOR, 0)},
            '{ROW_CMD, ACT_SEEK,   'hFFFE, 1'b1,
              snap('hFFFE, 'hFFFF, MODE_STOPPED, 1, ERR_NONE, 0)},
            '{ROW_CMD, ACT_SEEK,   'hFFFE, 1'b1,
              snap('hFFFE, 'hFFFF, MODE_STOPPED, 0, ERR_NONE, 0)},
            '{ROW_CMD, ACT_NEXT,   'h0000, 1'b1, snap(0, 'hFFFF, MODE_STOPPED, 1, ERR_NONE, 0)},
            '{ROW_CMD, ACT_PREV,   'h0000, 1'b1,
              snap('hFFFE, 'hFFFF, MODE_STOPPED, 1, ERR_NONE, 0)},
            '{ROW_CMD, ACT_LOAD,   'h0003, 1'b1, snap(2, 3, MODE_STOPPED, 1, ERR_NONE, 0)},
            '{ROW_CMD, ACT_PLAY,   'h0000, 1'b1, snap(2, 3, MODE_PLAYING, 1, ERR_NONE, 0)},
            '{ROW_PERIOD, ACT_TICK, 'h0001, 1'b0, '0},
            '{ROW_CMD, ACT_TICK,   'h0000, 1'b1, snap(0, 3, MODE_PLAYING, 1, ERR_NONE, 1)},
            '{ROW_CMD, ACT_TOGGLE, 'h0000, 1'b0, '0},
            '{ROW_CMD, ACT_PAUSE,  'h0000, 1'b0, '0},
            '{ROW_LOOP, ACT_TICK,  'h0000, 1'b0, '0},
            '{ROW_CMD, ACT_PREV,   'h0000, 1'b0, '0},
            '{ROW_CMD, ACT_TOGGLE, 'h0000, 1'b0, '0},
            '{ROW_CMD, ACT_SEEK,   'h0002, 1'b0, '0},
            '{ROW_CMD, ACT_TICK,   'h0000, 1'b0, '0},
            '{ROW_CMD, ACT_PLAY,   'h0000, 1'b0, '0},
            '{ROW_CMD, ACT_NEXT,   'h0000, 1'b0, '0},
            '{ROW_PERIOD, ACT_TICK, 'h0000, 1'b0, '0},
            '{ROW_CMD, ACT_PLAY,   'h0000, 1'b0, '0},
            '{ROW_CMD, ACT_TICK,   'h0000, 1'b0, '0},
            '{ROW_CMD, ACT_LOAD,   'h0000, 1'b0, '0},
            '{ROW_CMD, ACT_STOP,   'h0000, 1'b1, snap(0, 0, MODE_STOPPED, 1, ERR_NONE, 0)}
        };

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_CMD: send_cmd(plan[i].act, plan[i].val, plan[i].pinned, plan[i].want);
                ROW_PERIOD: begin
                    drain();
                    write_reg(REG_PERIOD, DATA_W'(plan[i].val));
                end
                default: begin
                    drain();
                    write_reg(REG_LOOP, DATA_W'(plan[i].val));
                end
            endcase
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            write_reg(REG_PERIOD, DATA_W'(PHASE_PERIOD[ph]));
            write_reg(REG_LOOP, DATA_W'(PHASE_LOOP[ph]));
            quiet = (ph == PHASES - 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                val  = VAL_W'($urandom);
                if (pick < 40) begin
                    act = ACT_TICK;
                end else if (pick < 48) begin
                    act = ACT_PLAY;
                end else if (pick < 53) begin
                    act = ACT_PAUSE;
                end else if (pick < 56) begin
                    act = ACT_STOP;
                end else if (pick < 62) begin
                    act = ACT_TOGGLE;
                end else if (pick < 71) begin
                    act = ACT_SEEK;
                    if (pick < 68)
                        val = VAL_W'($urandom_range(0, seq_total));
                end else if (pick < 79) begin
                    act = ACT_NEXT;
                end else if (pick < 86) begin
                    act = ACT_PREV;
                end else if (pick < 96) begin
                    act = ACT_LOAD;
                    if (pick < 93)
                        val = VAL_W'($urandom_range(1, 8));
                    else if (pick == 93)
                        val = '0;
                end else begin
                    act = ACT_W'($urandom_range(ACT_LOAD + 1, ACT_UNUSED));
                end
                send_cmd(act, val, 1'b0, '0);
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        bad_count += status_q.size();
        $display("%0d commands sent (%0d directed rows), %0d register writes over %0d settings",
                 cmds_sent, PLAN_N, reg_writes, PHASES);
        $display("%0d results compared, %0d failures", results_checked, bad_count);
        if (bad_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
